FILE: hw/rtl/slc_pkg.sv
package slc_pkg;

    // cache geometry
    localparam int SETS    = 64;
    localparam int WAYS    = 4;
    localparam int IDX_W   = $clog2(SETS);
    localparam int WAY_W   = $clog2(WAYS);
    localparam int FILL_W  = $clog2(WAYS + 1);

    // address split
    localparam int ADDR_W  = 32;
    localparam int TAG_W   = ADDR_W - IDX_W;
    localparam int OFF_W   = 4;
    localparam int SH_W    = $clog2((1 << OFF_W) + IDX_W);
    localparam logic [OFF_W-1:0] OFF_RESET = OFF_W'(6);

    // request queue between front and back
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    // one classified lookup
    typedef struct packed {
        logic [TAG_W-1:0] tag;
        logic [IDX_W-1:0] set;
    } t_req;

    // per-set replacement state: fill count and ways ordered lru to mru
    typedef struct packed {
        logic [FILL_W-1:0]           fill;
        logic [WAYS-1:0][WAY_W-1:0]  order;
    } t_meta;

endpackage

FILE: hw/rtl/slc_if.sv
interface slc_addr_if;
    logic                        valid;
    logic                        ready;
    logic [slc_pkg::ADDR_W-1:0]  address;

    modport source (output valid, output address, input ready);
    modport sink   (input valid, input address, output ready);
endinterface

interface slc_res_if;
    logic                        valid;
    logic                        ready;
    logic                        hit;
    logic [slc_pkg::WAY_W-1:0]   way;

    modport source (output valid, output hit, output way, input ready);
    modport sink   (input valid, input hit, input way, output ready);
endinterface

FILE: hw/rtl/slc_front.sv
module slc_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [slc_pkg::OFF_W-1:0]   i_cfg_data,
    slc_addr_if.sink                    i_addr,
    output logic                        o_q_valid,
    input  logic                        i_q_ready,
    output slc_pkg::t_req               o_q_req
);

    logic [slc_pkg::OFF_W-1:0]    r_off;
    slc_pkg::t_req                r_q [slc_pkg::Q_DEPTH];
    logic [slc_pkg::Q_PTR_W-1:0]  r_wr_ptr, n_wr_ptr;
    logic [slc_pkg::Q_PTR_W-1:0]  r_rd_ptr, n_rd_ptr;
    logic [slc_pkg::Q_CNT_W-1:0]  r_cnt, n_cnt;
    logic [slc_pkg::SH_W-1:0]     sh;
    slc_pkg::t_req                split;
    logic                         push, pop;

    // offset register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_off <= slc_pkg::OFF_RESET;
        end else if (i_cfg_we) begin
            r_off <= i_cfg_data;
        end
    end

    // split address into set index and tag
    always_comb begin
        sh        = slc_pkg::SH_W'(r_off) + slc_pkg::SH_W'(slc_pkg::IDX_W);
        split.set = slc_pkg::IDX_W'(i_addr.address >> r_off);
        split.tag = slc_pkg::TAG_W'(i_addr.address >> sh);
    end

    // queue handshake
    assign i_addr.ready = (r_cnt != slc_pkg::Q_CNT_W'(slc_pkg::Q_DEPTH));
    assign push         = i_addr.valid && i_addr.ready;
    assign o_q_valid    = (r_cnt != '0);
    assign pop          = o_q_valid && i_q_ready;
    assign o_q_req      = r_q[r_rd_ptr];

    // pointer and count update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_cnt    = r_cnt;
        if (push) begin
            n_wr_ptr = (r_wr_ptr == slc_pkg::Q_PTR_W'(slc_pkg::Q_DEPTH - 1)) ?
                       '0 : r_wr_ptr + 1'b1;
        end
        if (pop) begin
            n_rd_ptr = (r_rd_ptr == slc_pkg::Q_PTR_W'(slc_pkg::Q_DEPTH - 1)) ?
                       '0 : r_rd_ptr + 1'b1;
        end
        if (push && !pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (pop && !push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_cnt    <= n_cnt;
        end
    end

    // queue storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= split;
        end
    end

endmodule

FILE: hw/rtl/slc_back.sv
module slc_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_q_valid,
    output logic           o_q_ready,
    input  slc_pkg::t_req  i_q_req,
    slc_res_if.source      o_res
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_CMP  = 2'b10
    } t_back_state;

    t_back_state                     r_state, n_state;

    // tag and replacement storage, one word per set holding all ways
    logic [slc_pkg::WAYS-1:0][slc_pkg::TAG_W-1:0] r_tag_mem [slc_pkg::SETS];
    slc_pkg::t_meta                  r_meta_mem [slc_pkg::SETS];
    logic [slc_pkg::SETS-1:0]        r_set_vld;

    // lookup in flight
    logic [slc_pkg::WAYS-1:0][slc_pkg::TAG_W-1:0] r_tag_rd;
    slc_pkg::t_meta                  r_meta_rd;
    logic                            r_rd_vld;
    logic [slc_pkg::TAG_W-1:0]       r_tag;
    logic [slc_pkg::IDX_W-1:0]       r_set;

    // result register
    logic                            r_out_valid;
    logic                            r_out_hit;
    logic [slc_pkg::WAY_W-1:0]       r_out_way;

    logic                            rd_en, go, out_free;
    logic                            hit, found, tag_we;
    logic [slc_pkg::FILL_W-1:0]      cnt;
    logic [slc_pkg::WAY_W-1:0]       hway, pos, mway, wway;
    slc_pkg::t_meta                  cur_meta, n_meta;

    assign out_free  = !r_out_valid || o_res.ready;
    assign o_q_ready = (r_state == S_IDLE);
    assign rd_en     = i_q_valid && o_q_ready;
    assign go        = (r_state == S_CMP) && out_free;

    // sequencer: read cycle, then compare and update cycle
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (i_q_valid) n_state = S_CMP;
            S_CMP:   if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // registered read of the set
    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_tag_rd  <= r_tag_mem[i_q_req.set];
            r_meta_rd <= r_meta_mem[i_q_req.set];
            r_rd_vld  <= r_set_vld[i_q_req.set];
            r_tag     <= i_q_req.tag;
            r_set     <= i_q_req.set;
        end
    end

    // tag compare, lru position and new recency order
    always_comb begin
        cur_meta = r_rd_vld ? r_meta_rd : '0;
        cnt      = cur_meta.fill;
        hit      = 1'b0;
        hway     = '0;
        for (int i = 0; i < slc_pkg::WAYS; i++) begin
            if (!hit && slc_pkg::FILL_W'(i) < cnt && r_tag_rd[i] == r_tag) begin
                hit  = 1'b1;
                hway = slc_pkg::WAY_W'(i);
            end
        end

        // position of the way being promoted
        found = 1'b0;
        pos   = '0;
        if (hit) begin
            for (int i = 0; i < slc_pkg::WAYS; i++) begin
                if (!found && slc_pkg::FILL_W'(i) < cnt &&
                    cur_meta.order[i] == hway) begin
                    found = 1'b1;
                    pos   = slc_pkg::WAY_W'(i);
                end
            end
        end
        mway = hit ? hway : cur_meta.order[0];

        n_meta = cur_meta;
        tag_we = !hit;
        if (!hit && cnt < slc_pkg::FILL_W'(slc_pkg::WAYS)) begin
            // fill next free way in order
            wway        = slc_pkg::WAY_W'(cnt);
            n_meta.fill = cnt + 1'b1;
            for (int i = 0; i < slc_pkg::WAYS; i++) begin
                if (slc_pkg::FILL_W'(i) == cnt) begin
                    n_meta.order[i] = slc_pkg::WAY_W'(i);
                end
            end
        end else begin
            // hit or full miss: move entry at pos to the mru end
            wway = mway;
            for (int i = 0; i < slc_pkg::WAYS; i++) begin
                if (slc_pkg::WAY_W'(i) >= pos && slc_pkg::FILL_W'(i + 1) < cnt) begin
                    n_meta.order[i] = cur_meta.order[(i + 1) % slc_pkg::WAYS];
                end else if (slc_pkg::FILL_W'(i + 1) == cnt) begin
                    n_meta.order[i] = mway;
                end
            end
        end
    end

    // write back tag and replacement state
    always_ff @(posedge i_clk) begin
        if (go && tag_we) begin
            r_tag_mem[r_set][wway] <= r_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (go) begin
            r_meta_mem[r_set] <= n_meta;
        end
    end

    // control state and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_set_vld   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (go) begin
                r_set_vld[r_set] <= 1'b1;
                r_out_valid      <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (go) begin
            r_out_hit <= hit;
            r_out_way <= wway;
        end
    end

    assign o_res.valid = r_out_valid;
    assign o_res.hit   = r_out_hit;
    assign o_res.way   = r_out_way;

endmodule

FILE: hw/rtl/set_assoc_lru_cache_tags_core.sv
// channel   dir  fields                 beat
// i_addr    in   address[31:0]          one lookup per beat
// o_res     out  hit, way[1:0]          one result per lookup
// i_cfg_*   in   offset_bits[3:0]       write on i_cfg_we, no read-back
//
// each lookup passes the back end as a registered read of the set's tags
// and recency state, then compare plus write-back; a new request is taken
// only after that write-back. the 2-entry request queue and the result
// register let the address side keep taking beats while a result is stalled.
// synchronous active-low reset empties all sets and sets offset_bits to 6.
module set_assoc_lru_cache_tags_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [slc_pkg::OFF_W-1:0]   i_cfg_data,
    slc_addr_if.sink                    i_addr,
    slc_res_if.source                   o_res
);

    logic           q_valid;
    logic           q_ready;
    slc_pkg::t_req  q_req;

    // address split and request queue
    slc_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_addr     (i_addr),
        .o_q_valid  (q_valid),
        .i_q_ready  (q_ready),
        .o_q_req    (q_req)
    );

    // tag lookup and lru update
    slc_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .o_q_ready (q_ready),
        .i_q_req   (q_req),
        .o_res     (o_res)
    );

endmodule

FILE: hw/rtl/slc_check.sv
module slc_check (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_in_ready,
    input logic                       i_out_valid,
    input logic                       i_out_ready,
    input logic                       i_out_hit,
    input logic [slc_pkg::WAY_W-1:0]  i_out_way
);

    // reset leaves no result pending
    a_rst_no_res: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result beat present after reset");

    // reset empties the request queue
    a_rst_ready: assert property (@(posedge i_clk)
        !i_rst_n |=> i_in_ready)
        else $error("address channel not ready after reset");

    // stalled result beat stays
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result beat dropped while stalled");

    // stalled result payload holds
    a_res_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_out_hit) && $stable(i_out_way))
        else $error("result payload changed while stalled");

endmodule

bind set_assoc_lru_cache_tags_core slc_check u_check (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_addr.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_out_hit   (o_res.hit),
    .i_out_way   (o_res.way)
);
